>>> hdl/kts_pkg.sv
// Shared types and constants of the keyframe time sampler.
package kts_pkg;

  localparam int unsigned TimeBits   = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned MaxKeys    = 4096;
  localparam int unsigned KeyBits    = $clog2(MaxKeys);
  localparam int unsigned KeyCntBits = KeyBits + 1;
  localparam int unsigned LoopBits   = 16;
  localparam int unsigned ModeBits   = 2;
  localparam int unsigned CfgIdxBits = 4;
  localparam int unsigned LenBits    = TimeBits + 1;
  localparam int unsigned RemBits    = LenBits + 1;
  localparam int unsigned ProdBits   = TimeBits + KeyBits;
  localparam int unsigned DivBits    = ProdBits + FracBits;
  localparam int unsigned DivCntBits = $clog2(DivBits + 1);
  localparam int unsigned PadBits    = DivBits - TimeBits;

  localparam logic [ModeBits-1:0] ModeForward  = 2'd0;
  localparam logic [ModeBits-1:0] ModeReverse  = 2'd1;
  localparam logic [ModeBits-1:0] ModePingPong = 2'd2;

  typedef enum logic [1:0] {
    StatusIdle  = 2'd0,
    StatusHold  = 2'd1,
    StatusBlend = 2'd2
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgBeginTime = 4'd0,
    CfgDuration  = 4'd1,
    CfgClipIn    = 4'd2,
    CfgClipOut   = 4'd3,
    CfgPauseTime = 4'd4,
    CfgLoopCount = 4'd5,
    CfgPlayMode  = 4'd6,
    CfgKeyCount  = 4'd7
  } cfg_idx_e;

endpackage

>>> hdl/keyframe_time_sampler.sv
// Keyframe time sampler: folds a sample time into a looping animation and picks keys.
// One shared restoring divider retires one quotient bit a cycle: a 32-bit quotient for the loop
// count (none for a zero cycle length), 32 bits for a clipped fold and 60 for key index and blend.
// The input stays stalled until the result is in the output register, so one sample is taken at
// a time. Reset is asynchronous and active low and loads register defaults.
module keyframe_time_sampler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [kts_pkg::TimeBits-1:0]     sample_time_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [kts_pkg::KeyBits-1:0]      lower_index_o,
  output logic [kts_pkg::KeyBits-1:0]      upper_index_o,
  output logic [kts_pkg::FracBits-1:0]     blend_o,
  output logic                             reversed_o,
  output logic [kts_pkg::TimeBits-1:0]     completed_loops_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [kts_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [kts_pkg::TimeBits-1:0]     cfg_data_i
);

  typedef enum logic [3:0] {
    StIdle,
    StDiv1,
    StCheck,
    StDiv2,
    StFold,
    StPhase,
    StMul,
    StDiv3,
    StKeys,
    StFin
  } state_e;

  state_e state_q;

  logic [kts_pkg::TimeBits-1:0]   begin_q, dur_q, clip_in_q, clip_out_q, pause_q;
  logic [kts_pkg::LoopBits-1:0]   loop_q;
  logic [kts_pkg::ModeBits-1:0]   mode_q;
  logic [kts_pkg::KeyCntBits-1:0] key_cnt_q;

  logic [kts_pkg::TimeBits-1:0]   prev_q;
  logic                           dir_q;
  logic [kts_pkg::TimeBits-1:0]   elapsed_q;

  logic                           active_q;
  logic [kts_pkg::LenBits-1:0]    phase_q;
  logic [kts_pkg::TimeBits-1:0]   mirror_q;
  logic [kts_pkg::TimeBits-1:0]   loops_q;
  kts_pkg::status_e               res_status_q;
  logic [kts_pkg::KeyBits-1:0]    res_lower_q, res_upper_q;
  logic [kts_pkg::FracBits-1:0]   res_blend_q;

  logic [kts_pkg::DivBits-1:0]    div_num_q, div_quo_q;
  logic [kts_pkg::RemBits-1:0]    div_rem_q;
  logic [kts_pkg::LenBits-1:0]    div_den_q;
  logic [kts_pkg::DivCntBits-1:0] div_cnt_q;

  logic                           out_valid_q;
  logic [1:0]                     out_status_q;
  logic [kts_pkg::KeyBits-1:0]    out_lower_q, out_upper_q;
  logic [kts_pkg::FracBits-1:0]   out_blend_q;
  logic                           out_rev_q;
  logic [kts_pkg::TimeBits-1:0]   out_loops_q;

  logic [kts_pkg::LenBits-1:0]    start_sum, real_len;
  logic                           real_zero, active_now, in_xfer, out_free;
  logic [kts_pkg::TimeBits-1:0]   elapsed_new, loops_now, fold_den;
  logic [kts_pkg::LenBits-1:0]    rem_now;
  logic                           past_end;
  logic [kts_pkg::RemBits-1:0]    rem_shift;
  logic [kts_pkg::RemBits:0]      rem_diff;
  logic                           rem_ge;
  logic                           toggle, dir_next;
  logic [kts_pkg::KeyCntBits-1:0] key_clamp, upper_sum;
  logic [kts_pkg::KeyBits-1:0]    key_max, lower_now;
  logic [kts_pkg::ProdBits-1:0]   product;

  assign start_sum   = {1'b0, begin_q} + {1'b0, clip_in_q};
  assign real_len    = (clip_out_q != '0) ? {1'b0, clip_out_q} : {1'b0, dur_q} + {1'b0, pause_q};
  assign real_zero   = (real_len == '0);
  assign active_now  = ({1'b0, sample_time_i} >= start_sum);
  assign elapsed_new = sample_time_i - begin_q;
  assign in_xfer     = in_valid_i && (state_q == StIdle);
  assign out_free    = !out_valid_q || !out_stall_i;

  assign loops_now = div_quo_q[kts_pkg::TimeBits-1:0];
  assign rem_now   = div_rem_q[kts_pkg::LenBits-1:0];
  assign past_end  = real_zero ? (elapsed_q != '0)
                   : ((loops_now > {{(kts_pkg::TimeBits-kts_pkg::LoopBits){1'b0}}, loop_q}) ||
                      ((loops_now == {{(kts_pkg::TimeBits-kts_pkg::LoopBits){1'b0}}, loop_q}) &&
                       (rem_now != '0)));
  assign fold_den  = (clip_out_q > clip_in_q) ? clip_out_q - clip_in_q : clip_in_q - clip_out_q;

  assign rem_shift = {div_rem_q[kts_pkg::RemBits-2:0], div_num_q[kts_pkg::DivBits-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, div_den_q};
  assign rem_ge    = !rem_diff[kts_pkg::RemBits];

  assign toggle   = (phase_q < {1'b0, prev_q}) && (mode_q == kts_pkg::ModePingPong);
  assign dir_next = dir_q ^ toggle;

  assign key_clamp = (key_cnt_q == '0) ? kts_pkg::KeyCntBits'(1)
                   : (key_cnt_q > kts_pkg::KeyCntBits'(kts_pkg::MaxKeys))
                     ? kts_pkg::KeyCntBits'(kts_pkg::MaxKeys) : key_cnt_q;
  assign key_max   = kts_pkg::KeyBits'(key_clamp - kts_pkg::KeyCntBits'(1));
  assign product   = {{kts_pkg::KeyBits{1'b0}}, mirror_q} *
                     {{kts_pkg::TimeBits{1'b0}}, key_max};
  assign lower_now = div_quo_q[kts_pkg::FracBits +: kts_pkg::KeyBits];
  assign upper_sum = {1'b0, lower_now} + kts_pkg::KeyCntBits'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      begin_q      <= '0;
      dur_q        <= '0;
      clip_in_q    <= '0;
      clip_out_q   <= '0;
      pause_q      <= '0;
      loop_q       <= kts_pkg::LoopBits'(1);
      mode_q       <= kts_pkg::ModeForward;
      key_cnt_q    <= kts_pkg::KeyCntBits'(2);
      prev_q       <= '0;
      dir_q        <= 1'b0;
      elapsed_q    <= '0;
      active_q     <= 1'b0;
      phase_q      <= '0;
      mirror_q     <= '0;
      loops_q      <= '0;
      res_status_q <= kts_pkg::StatusIdle;
      res_lower_q  <= '0;
      res_upper_q  <= '0;
      res_blend_q  <= '0;
      div_num_q    <= '0;
      div_quo_q    <= '0;
      div_rem_q    <= '0;
      div_den_q    <= '0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_lower_q  <= '0;
      out_upper_q  <= '0;
      out_blend_q  <= '0;
      out_rev_q    <= 1'b0;
      out_loops_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        case (cfg_index_i)
          kts_pkg::CfgBeginTime: begin
            begin_q <= cfg_data_i;
            dir_q   <= (mode_q == kts_pkg::ModeReverse);
          end
          kts_pkg::CfgDuration: begin
            dur_q <= cfg_data_i;
            dir_q <= (mode_q == kts_pkg::ModeReverse);
          end
          kts_pkg::CfgClipIn: begin
            clip_in_q <= cfg_data_i;
            dir_q     <= (mode_q == kts_pkg::ModeReverse);
          end
          kts_pkg::CfgClipOut: begin
            clip_out_q <= cfg_data_i;
            dir_q      <= (mode_q == kts_pkg::ModeReverse);
          end
          kts_pkg::CfgPauseTime: begin
            pause_q <= cfg_data_i;
            dir_q   <= (mode_q == kts_pkg::ModeReverse);
          end
          kts_pkg::CfgLoopCount: begin
            loop_q <= cfg_data_i[kts_pkg::LoopBits-1:0];
            dir_q  <= (mode_q == kts_pkg::ModeReverse);
          end
          kts_pkg::CfgPlayMode: begin
            mode_q <= cfg_data_i[kts_pkg::ModeBits-1:0];
            dir_q  <= (cfg_data_i[kts_pkg::ModeBits-1:0] == kts_pkg::ModeReverse);
          end
          kts_pkg::CfgKeyCount: begin
            key_cnt_q <= cfg_data_i[kts_pkg::KeyCntBits-1:0];
            dir_q     <= (mode_q == kts_pkg::ModeReverse);
          end
          default: begin
          end
        endcase
      end

      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            active_q    <= active_now;
            res_lower_q <= '0;
            res_upper_q <= '0;
            res_blend_q <= '0;
            if (active_now) begin
              elapsed_q <= elapsed_new;
            end
            div_num_q <= {(active_now ? elapsed_new : elapsed_q), {kts_pkg::PadBits{1'b0}}};
            div_quo_q <= '0;
            div_rem_q <= '0;
            div_den_q <= real_len;
            div_cnt_q <= kts_pkg::DivCntBits'(kts_pkg::TimeBits);
            state_q   <= real_zero ? StCheck : StDiv1;
          end
        end
        StDiv1, StDiv2, StDiv3: begin
          div_num_q <= {div_num_q[kts_pkg::DivBits-2:0], 1'b0};
          div_quo_q <= {div_quo_q[kts_pkg::DivBits-2:0], rem_ge};
          div_rem_q <= rem_ge ? rem_diff[kts_pkg::RemBits-1:0] : rem_shift;
          div_cnt_q <= div_cnt_q - kts_pkg::DivCntBits'(1);
          if (div_cnt_q == kts_pkg::DivCntBits'(1)) begin
            case (state_q)
              StDiv1:  state_q <= StCheck;
              StDiv2:  state_q <= StFold;
              default: state_q <= StKeys;
            endcase
          end
        end
        StCheck: begin
          loops_q <= loops_now;
          if (!active_q) begin
            res_status_q <= kts_pkg::StatusIdle;
            state_q      <= StFin;
          end else if ((loop_q != '0) && past_end) begin
            res_status_q <= (clip_out_q != '0) ? kts_pkg::StatusIdle : kts_pkg::StatusHold;
            state_q      <= StFin;
          end else if ((clip_out_q == '0) && (clip_in_q == '0)) begin
            if (real_zero) begin
              res_status_q <= kts_pkg::StatusHold;
              state_q      <= StFin;
            end else begin
              phase_q <= rem_now;
              state_q <= StPhase;
            end
          end else if (elapsed_q > clip_out_q) begin
            if (fold_den == '0) begin
              res_status_q <= kts_pkg::StatusHold;
              state_q      <= StFin;
            end else begin
              div_num_q <= {elapsed_q - clip_in_q, {kts_pkg::PadBits{1'b0}}};
              div_quo_q <= '0;
              div_rem_q <= '0;
              div_den_q <= {1'b0, fold_den};
              div_cnt_q <= kts_pkg::DivCntBits'(kts_pkg::TimeBits);
              state_q   <= StDiv2;
            end
          end else begin
            phase_q <= {1'b0, elapsed_q};
            state_q <= StPhase;
          end
        end
        StFold: begin
          phase_q <= {1'b0, clip_in_q} + {1'b0, div_rem_q[kts_pkg::TimeBits-1:0]};
          state_q <= StPhase;
        end
        StPhase: begin
          dir_q  <= dir_next;
          prev_q <= phase_q[kts_pkg::TimeBits] ? '1 : phase_q[kts_pkg::TimeBits-1:0];
          if ((phase_q > {1'b0, dur_q}) || (dur_q == '0)) begin
            res_status_q <= kts_pkg::StatusHold;
            state_q      <= StFin;
          end else begin
            mirror_q <= dir_next ? dur_q - phase_q[kts_pkg::TimeBits-1:0]
                                 : phase_q[kts_pkg::TimeBits-1:0];
            state_q  <= StMul;
          end
        end
        StMul: begin
          div_num_q <= {product, {kts_pkg::FracBits{1'b0}}};
          div_quo_q <= '0;
          div_rem_q <= '0;
          div_den_q <= {1'b0, dur_q};
          div_cnt_q <= kts_pkg::DivCntBits'(kts_pkg::DivBits);
          state_q   <= StDiv3;
        end
        StKeys: begin
          res_status_q <= kts_pkg::StatusBlend;
          res_lower_q  <= lower_now;
          res_upper_q  <= (upper_sum >= key_clamp) ? '0 : upper_sum[kts_pkg::KeyBits-1:0];
          res_blend_q  <= div_quo_q[kts_pkg::FracBits-1:0];
          state_q      <= StFin;
        end
        StFin: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_lower_q  <= res_lower_q;
            out_upper_q  <= res_upper_q;
            out_blend_q  <= res_blend_q;
            out_rev_q    <= dir_q;
            out_loops_q  <= loops_q;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_stall_o        = (state_q != StIdle);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign lower_index_o     = out_lower_q;
  assign upper_index_o     = out_upper_q;
  assign blend_o           = out_blend_q;
  assign reversed_o        = out_rev_q;
  assign completed_loops_o = out_loops_q;

endmodule

>>> sim/keyframe_time_sampler_tb.sv
// Self-checking testbench of the keyframe time sampler with directed and random samples.
module keyframe_time_sampler_tb;

  localparam int unsigned CycleLimit     = 1000000;
  localparam int unsigned LongHoldCycles = 600;
  localparam int unsigned PhaseCount     = 24;
  localparam int unsigned PhaseItems     = 54;
  localparam int unsigned CfgFirstUnused = kts_pkg::CfgKeyCount + 1;
  localparam int unsigned CfgSlots       = 1 << kts_pkg::CfgIdxBits;
  localparam logic [kts_pkg::ModeBits-1:0] ModeUndefined = 2'd3;

  typedef struct packed {
    kts_pkg::status_e                status;
    logic [kts_pkg::KeyBits-1:0]     lower;
    logic [kts_pkg::KeyBits-1:0]     upper;
    logic [kts_pkg::FracBits-1:0]    blend;
    logic                            reversed;
    logic [kts_pkg::TimeBits-1:0]    loops;
  } key_sample_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            in_valid_i    = 1'b0;
  logic                            in_stall_o;
  logic [kts_pkg::TimeBits-1:0]    sample_time_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i   = 1'b0;
  logic [1:0]                      status_o;
  logic [kts_pkg::KeyBits-1:0]     lower_index_o;
  logic [kts_pkg::KeyBits-1:0]     upper_index_o;
  logic [kts_pkg::FracBits-1:0]    blend_o;
  logic                            reversed_o;
  logic [kts_pkg::TimeBits-1:0]    completed_loops_o;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [kts_pkg::CfgIdxBits-1:0]  cfg_index_i   = '0;
  logic [kts_pkg::TimeBits-1:0]    cfg_data_i    = '0;

  // Predictor copy of the registers and the animation state.
  logic [kts_pkg::TimeBits-1:0]    anim_begin    = '0;
  logic [kts_pkg::TimeBits-1:0]    anim_duration = '0;
  logic [kts_pkg::TimeBits-1:0]    anim_clip_in  = '0;
  logic [kts_pkg::TimeBits-1:0]    anim_clip_out = '0;
  logic [kts_pkg::TimeBits-1:0]    anim_pause    = '0;
  logic [kts_pkg::LoopBits-1:0]    anim_loops    = 16'd1;
  logic [kts_pkg::ModeBits-1:0]    anim_mode     = kts_pkg::ModeForward;
  logic [kts_pkg::KeyCntBits-1:0]  anim_keys     = 13'd2;
  logic [kts_pkg::TimeBits-1:0]    last_phase    = '0;
  logic                            play_reversed = 1'b0;
  logic [kts_pkg::TimeBits-1:0]    held_elapsed  = '0;

  logic [kts_pkg::TimeBits-1:0]    pending_times[$];
  key_sample_t                     due_samples[$];
  int unsigned                     samples_queued  = 0;
  int unsigned                     samples_sent    = 0;
  int unsigned                     results_checked = 0;
  int unsigned                     mismatches      = 0;
  int unsigned                     settings_done   = 0;
  int unsigned                     send_idle_pct   = 0;
  int unsigned                     recv_stall_pct  = 0;
  logic                            recv_hold       = 1'b0;
  event                            long_hold_ev;

  keyframe_time_sampler dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_time_i     (sample_time_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .lower_index_o     (lower_index_o),
    .upper_index_o     (upper_index_o),
    .blend_o           (blend_o),
    .reversed_o        (reversed_o),
    .completed_loops_o (completed_loops_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void apply_reg(input logic [kts_pkg::CfgIdxBits-1:0] idx,
                                    input logic [kts_pkg::TimeBits-1:0] val);
    case (idx)
      kts_pkg::CfgBeginTime: anim_begin    = val;
      kts_pkg::CfgDuration:  anim_duration = val;
      kts_pkg::CfgClipIn:    anim_clip_in  = val;
      kts_pkg::CfgClipOut:   anim_clip_out = val;
      kts_pkg::CfgPauseTime: anim_pause    = val;
      kts_pkg::CfgLoopCount: anim_loops    = val[kts_pkg::LoopBits-1:0];
      kts_pkg::CfgPlayMode:  anim_mode     = val[kts_pkg::ModeBits-1:0];
      kts_pkg::CfgKeyCount:  anim_keys     = val[kts_pkg::KeyCntBits-1:0];
      default: return;
    endcase
    play_reversed = (anim_mode == kts_pkg::ModeReverse);
  endfunction

  function automatic logic [63:0] cycle_length();
    if (anim_clip_out != 0) begin
      return 64'(anim_clip_out);
    end
    return 64'(anim_duration) + 64'(anim_pause);
  endfunction

  task automatic predict_sample(input logic [kts_pkg::TimeBits-1:0] t);
    logic [63:0] cyc_len, elapsed, phase, span, keys, num, idx_lo, idx_hi, rem, frac;
    logic        fold_ok;
    key_sample_t r;
    r = '0;
    r.status = kts_pkg::StatusIdle;
    cyc_len = cycle_length();
    if (64'(t) >= 64'(anim_begin) + 64'(anim_clip_in)) begin
      elapsed = 64'(t) - 64'(anim_begin);
      held_elapsed = elapsed[kts_pkg::TimeBits-1:0];
      if (anim_loops != 0 && elapsed > cyc_len * 64'(anim_loops)) begin
        if (anim_clip_out != 0) begin
          r.status = kts_pkg::StatusIdle;
        end else begin
          r.status = kts_pkg::StatusHold;
        end
      end else begin
        phase = elapsed;
        fold_ok = 1'b1;
        if (anim_clip_out == 0 && anim_clip_in == 0) begin
          if (cyc_len == 0) fold_ok = 1'b0;
          else phase = elapsed % cyc_len;
        end else if (elapsed > 64'(anim_clip_out)) begin
          if (anim_clip_out > anim_clip_in) span = 64'(anim_clip_out) - 64'(anim_clip_in);
          else span = 64'(anim_clip_in) - 64'(anim_clip_out);
          if (span == 0) fold_ok = 1'b0;
          else phase = 64'(anim_clip_in) + (elapsed - 64'(anim_clip_in)) % span;
        end
        if (!fold_ok) begin
          r.status = kts_pkg::StatusHold;
        end else begin
          if (phase < 64'(last_phase) && anim_mode == kts_pkg::ModePingPong) begin
            play_reversed = !play_reversed;
          end
          last_phase = (phase > 64'hFFFF_FFFF) ? '1 : phase[kts_pkg::TimeBits-1:0];
          if (phase > 64'(anim_duration) || anim_duration == 0) begin
            r.status = kts_pkg::StatusHold;
          end else begin
            keys = 64'(anim_keys);
            if (keys == 0) keys = 64'd1;
            if (keys > 64'(kts_pkg::MaxKeys)) keys = 64'(kts_pkg::MaxKeys);
            if (play_reversed) phase = 64'(anim_duration) - phase;
            num = phase * (keys - 64'd1);
            idx_lo = num / 64'(anim_duration);
            rem = num % 64'(anim_duration);
            idx_hi = idx_lo + 64'd1;
            if (idx_hi >= keys) idx_hi = 0;
            frac = (rem << kts_pkg::FracBits) / 64'(anim_duration);
            r.lower = idx_lo[kts_pkg::KeyBits-1:0];
            r.upper = idx_hi[kts_pkg::KeyBits-1:0];
            r.blend = frac[kts_pkg::FracBits-1:0];
            r.status = kts_pkg::StatusBlend;
          end
        end
      end
    end
    r.reversed = play_reversed;
    r.loops = (cyc_len != 0) ? 32'(64'(held_elapsed) / cyc_len) : '0;
    due_samples.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : sample_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_sample(sample_time_i);
        samples_sent++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_times.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i    <= 1'b1;
          sample_time_i <= pending_times.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    key_sample_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_samples.size() == 0) begin
          $display("%0t: result mismatch, expected none, actual status %0d", $time, status_o);
          mismatches++;
        end else begin
          want = due_samples.pop_front();
          check_field("status", want.status, status_o);
          check_field("lower_index", want.lower, lower_index_o);
          check_field("upper_index", want.upper, upper_index_o);
          check_field("blend", want.blend, blend_o);
          check_field("reversed", want.reversed, reversed_o);
          check_field("completed_loops", want.loops, completed_loops_o);
          results_checked++;
        end
      end
      out_stall_i <= recv_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : receiver_hold
    forever begin
      @(long_hold_ev);
      recv_hold <= 1'b1;
      repeat (LongHoldCycles) @(posedge clk_i);
      recv_hold <= 1'b0;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycles,
             due_samples.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic write_reg(input logic [kts_pkg::CfgIdxBits-1:0] idx,
                           input logic [kts_pkg::TimeBits-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_time(input logic [kts_pkg::TimeBits-1:0] t);
    pending_times.push_back(t);
    samples_queued++;
  endtask

  task automatic wait_idle();
    while (samples_sent != samples_queued || due_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic pick_config();
    logic [kts_pkg::TimeBits-1:0]   b, dur, ci, co, pz;
    logic [kts_pkg::LoopBits-1:0]   lc;
    logic [kts_pkg::KeyCntBits-1:0] kc;
    case ($urandom_range(9))
      0:       dur = '0;
      1:       dur = '1;
      2, 3:    dur = $urandom;
      default: dur = $urandom_range(3000, 1);
    endcase
    case ($urandom_range(7))
      0, 1:    pz = $urandom_range(500);
      2:       pz = $urandom;
      default: pz = '0;
    endcase
    case ($urandom_range(9))
      5, 6, 7: ci = $urandom_range(dur);
      8:       ci = $urandom;
      default: ci = '0;
    endcase
    case ($urandom_range(9))
      5:       co = ci;
      6:       co = $urandom_range(ci);
      7, 8:    co = ci + $urandom_range(2000, 1);
      9:       co = $urandom;
      default: co = '0;
    endcase
    case ($urandom_range(9))
      4:       b = '0;
      5:       b = '1;
      6, 7:    b = $urandom;
      default: b = $urandom_range(1000);
    endcase
    case ($urandom_range(9))
      0, 1:    lc = '0;
      7:       lc = '1;
      8, 9:    lc = 16'($urandom);
      default: lc = 16'($urandom_range(5, 1));
    endcase
    case ($urandom_range(9))
      0:       kc = '0;
      1:       kc = 13'd1;
      2:       kc = 13'(kts_pkg::MaxKeys);
      3:       kc = 13'($urandom_range(8191, kts_pkg::MaxKeys + 1));
      default: kc = 13'($urandom_range(64, 2));
    endcase
    write_reg(kts_pkg::CfgBeginTime, b);
    write_reg(kts_pkg::CfgDuration, dur);
    write_reg(kts_pkg::CfgClipIn, ci);
    write_reg(kts_pkg::CfgClipOut, co);
    write_reg(kts_pkg::CfgPauseTime, pz);
    write_reg(kts_pkg::CfgLoopCount, 32'(lc) | ($urandom & 32'hFFFF_0000));
    write_reg(kts_pkg::CfgKeyCount, 32'(kc));
    write_reg(kts_pkg::CfgPlayMode, 32'($urandom_range(3)));
    if ($urandom_range(2) == 0) begin
      write_reg(4'($urandom_range(CfgSlots - 1, CfgFirstUnused)), $urandom);
    end
    settings_done++;
  endtask

  // Mostly a rising sweep through the passes, with jumps, pass boundaries and early samples.
  task automatic queue_sweep(input int unsigned count);
    logic [63:0]         start, cyc_len, span, pos, mark;
    logic [31:0]         step_max;
    int unsigned         passes;
    start   = 64'(anim_begin) + 64'(anim_clip_in);
    cyc_len = cycle_length();
    passes  = (anim_loops == 0) ? 32'd3 : 32'(anim_loops) + 32'd1;
    span    = cyc_len * passes + 8;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    step_max = 32'(span / count * 2 + 1);
    pos = 0;
    repeat (count) begin
      case ($urandom_range(9))
        0: queue_time($urandom);
        1: queue_time(32'(start - 64'($urandom_range(3, 1))));
        2: queue_time(32'(start + 64'($urandom_range(32'(span)))));
        3: begin
          mark = 64'(anim_begin) + cyc_len * 64'($urandom_range(passes));
          queue_time(32'(mark + 64'($urandom_range(2)) - 64'd1));
        end
        default: begin
          pos = pos + 64'($urandom_range(step_max));
          queue_time(32'(start + pos));
        end
      endcase
    end
  endtask

  initial begin : sequencer
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: no cycle length, so every active sample holds the end value.
    queue_time(32'd0);
    queue_time('1);
    wait_idle();

    write_reg(kts_pkg::CfgBeginTime, 32'd100);
    write_reg(kts_pkg::CfgDuration, 32'd1000);
    write_reg(kts_pkg::CfgPauseTime, 32'd50);
    write_reg(kts_pkg::CfgLoopCount, 32'd2);
    write_reg(kts_pkg::CfgKeyCount, 32'd5);
    queue_time(32'd99);
    queue_time(32'd100);
    queue_time(32'd433);
    queue_time(32'd1100);
    queue_time(32'd1120);
    queue_time(32'd2200);
    queue_time(32'd2201);
    wait_idle();

    write_reg(kts_pkg::CfgPlayMode, 32'(kts_pkg::ModeReverse));
    queue_time(32'd433);
    queue_time(32'd900);
    wait_idle();

    write_reg(kts_pkg::CfgPlayMode, 32'(kts_pkg::ModePingPong));
    queue_time(32'd600);
    queue_time(32'd900);
    queue_time(32'd1200);
    wait_idle();

    write_reg(kts_pkg::CfgPlayMode, 32'(ModeUndefined));
    queue_time(32'd433);
    wait_idle();

    write_reg(kts_pkg::CfgPlayMode, 32'(kts_pkg::ModeForward));
    write_reg(kts_pkg::CfgClipIn, 32'd200);
    write_reg(kts_pkg::CfgClipOut, 32'd600);
    queue_time(32'd299);
    queue_time(32'd500);
    queue_time(32'd1000);
    queue_time(32'd1400);
    wait_idle();

    write_reg(kts_pkg::CfgClipIn, 32'd600);
    queue_time(32'd1000);
    wait_idle();

    write_reg(kts_pkg::CfgClipIn, 32'd0);
    write_reg(kts_pkg::CfgClipOut, 32'd0);
    write_reg(kts_pkg::CfgKeyCount, 32'd0);
    queue_time(32'd433);
    wait_idle();
    write_reg(kts_pkg::CfgKeyCount, 32'd8191);
    queue_time(32'd1099);
    wait_idle();

    write_reg(kts_pkg::CfgBeginTime, 32'hFFFF_FFF0);
    write_reg(kts_pkg::CfgClipIn, 32'h0000_0020);
    queue_time('1);
    wait_idle();

    write_reg(kts_pkg::CfgBeginTime, 32'd0);
    write_reg(kts_pkg::CfgClipIn, 32'd0);
    write_reg(kts_pkg::CfgLoopCount, 32'd0);
    write_reg(kts_pkg::CfgDuration, '1);
    write_reg(kts_pkg::CfgPauseTime, '1);
    write_reg(kts_pkg::CfgPlayMode, 32'(kts_pkg::ModePingPong));
    write_reg(kts_pkg::CfgIdxBits'(CfgFirstUnused), '1);
    queue_time('1);
    wait_idle();
    settings_done += 10;

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      pick_config();
      if (p == 5) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_sweep(PhaseItems);
        -> long_hold_ev;
      end else if (p == 9) begin
        queue_sweep(PhaseItems / 2);
        wait_idle();
        queue_sweep(PhaseItems / 2);
      end else begin
        queue_sweep(PhaseItems);
      end
      wait_idle();
    end

    repeat (150) @(posedge clk_i);
    $display("Checked %0d of %0d samples over %0d register settings, %0d mismatches.",
             results_checked, samples_sent, settings_done, mismatches);
    $display("Covered clipping, ping-pong, reverse, pass ends and idle, stall and hold-off phases.");
    if (mismatches == 0 && due_samples.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
